/* hw/rtl/iba_pkg.sv */
// ----------------------------------------------------------------------------
// iba_pkg
// shared constants and types for the image bin accumulator
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int SIDE_W      = $clog2(MAX_SIDE);
    localparam int ADDR_W      = 2 * SIDE_W;
    localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
    localparam int PIXEL_WIDTH = 48;
    localparam int OUT_W       = 48;

    localparam logic [PIXEL_WIDTH-1:0] PIX_MAX  = {PIXEL_WIDTH{1'b1}};
    localparam logic [PIXEL_WIDTH-1:0] ONE_Q16  = PIXEL_WIDTH'(65536);
    localparam logic [PIXEL_WIDTH-1:0] HALF_Q16 = PIXEL_WIDTH'(32768);

    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_MERGE   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_COMBINE = 2'd3;

    localparam logic [1:0] MODE_INTENSITY = 2'd0;
    localparam logic [1:0] MODE_BW        = 2'd1;
    localparam logic [1:0] MODE_HIST      = 2'd2;
    localparam logic [1:0] MODE_OFF       = 2'd3;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIDE = 1'b1;

    // datapath operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_CAPTURE = 3'd1;
    localparam logic [2:0] OP_ADDR    = 3'd2;
    localparam logic [2:0] OP_RD      = 3'd3;
    localparam logic [2:0] OP_WR      = 3'd4;
    localparam logic [2:0] OP_SWEEP   = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       clr_run;   // sweep also clears run (reset clear pass)
        logic       clr_res;
        logic       merge;     // sweep merges run into result
    } iba_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       sweep_last;
    } iba_sts_t;

endpackage

/* hw/rtl/image_bin_accumulator.sv */
// ----------------------------------------------------------------------------
// image_bin_accumulator
// 2d histogram accumulator with run and result images of 128x128 pixels
// ----------------------------------------------------------------------------
// channel   dir   fields
// s_axis    in    tdata: action, coord_x, coord_y, brightness, differential,
//                        pixel_row, pixel_col, external_value
// m_axis    out   tdata: pixel_value, saturated
// cfg       in    cfg_we, cfg_index, cfg_data
//
// sample, read and combine step through capture, address, read and write, then wait for the output beat
// merge sweeps all 16384 addresses one pixel per cycle, then drains and waits
// for the output beat
// after reset a clear pass over all addresses runs before s_tready rises
// one item at a time; s_tready stays low until the result beat is taken
// ----------------------------------------------------------------------------
module image_bin_accumulator import iba_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], coord_x[18:2], coord_y[35:19], brightness[59:36],
    // differential[75:60], pixel_row[82:76], pixel_col[89:83],
    // external_value[137:90], zero pad
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_value[47:0], saturated[48], zero pad
    output logic [55:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);

    logic [1:0]       mode_reg;
    logic [7:0]       side_reg;
    iba_cmd_t         cmd;
    iba_sts_t         sts;
    logic [OUT_W-1:0] value;
    logic             sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_INTENSITY;
            side_reg <= 8'd128;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE: mode_reg <= cfg_data[1:0];
                CFG_SIDE: side_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    iba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_tvalid && s_tready),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    iba_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode_reg),
        .side_cfg  (side_reg),
        .in_action (s_tdata[1:0]),
        .in_x      (s_tdata[18:2]),
        .in_y      (s_tdata[35:19]),
        .in_bright (s_tdata[59:36]),
        .in_diff   (s_tdata[75:60]),
        .in_row    (s_tdata[82:76]),
        .in_col    (s_tdata[89:83]),
        .in_ext    (s_tdata[137:90]),
        .res_value (value),
        .res_sat   (sat)
    );

    assign m_tdata = {7'd0, sat, value};

endmodule

/* hw/rtl/iba_datapath.sv */
// ----------------------------------------------------------------------------
// iba_datapath
// operand registers, coordinate scaling, image memories and pixel update
// ----------------------------------------------------------------------------
module iba_datapath import iba_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iba_cmd_t               cmd,
    output iba_sts_t               sts,
    input  logic [1:0]             mode,
    input  logic [7:0]             side_cfg,
    input  logic [1:0]             in_action,
    input  logic [16:0]            in_x,
    input  logic [16:0]            in_y,
    input  logic [23:0]            in_bright,
    input  logic [15:0]            in_diff,
    input  logic [6:0]             in_row,
    input  logic [6:0]             in_col,
    input  logic [47:0]            in_ext,
    output logic [OUT_W-1:0]       res_value,
    output logic                   res_sat
);

    logic [PIXEL_WIDTH-1:0] run_mem [DEPTH];
    logic [PIXEL_WIDTH-1:0] res_mem [DEPTH];

    logic [1:0]             act_reg;
    logic [16:0]            x_reg, y_reg;
    logic [23:0]            br_reg;
    logic [15:0]            df_reg;
    logic [6:0]             row_in_reg, col_in_reg;
    logic [47:0]            ext_reg;
    logic [SIDE_W:0]        side_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   inreg_reg;
    logic [39:0]            prod_reg;
    logic [PIXEL_WIDTH-1:0] run_rd_reg, res_rd_reg;
    logic [ADDR_W-1:0]      sw_addr_reg, sw_wa_reg;
    logic                   sw_vld_reg, sw_inreg_reg;
    logic [OUT_W-1:0]       value_reg;
    logic                   sat_reg;

    logic [SIDE_W:0]        side_eff;
    logic [SIDE_W+17:0]     px, py;
    logic [SIDE_W-1:0]      col_s, row_s;
    logic [PIXEL_WIDTH:0]   sum_run, sum_res, sum_sw;
    logic [PIXEL_WIDTH-1:0] add_run;

    always_comb begin
        if (side_cfg == 8'd0) side_eff = (SIDE_W+1)'(1);
        else if ({1'b0, side_cfg} > 9'(MAX_SIDE)) side_eff = (SIDE_W+1)'(MAX_SIDE);
        else side_eff = (SIDE_W+1)'(side_cfg);
        px = (SIDE_W+18)'(x_reg) * (SIDE_W+18)'(side_reg);
        py = (SIDE_W+18)'(y_reg) * (SIDE_W+18)'(side_reg);
        col_s = (px[SIDE_W+17:16] >= (SIDE_W+2)'(side_reg))
            ? SIDE_W'(side_reg - 1'b1) : px[SIDE_W+15:16];
        row_s = (py[SIDE_W+17:16] >= (SIDE_W+2)'(side_reg))
            ? SIDE_W'(side_reg - 1'b1) : py[SIDE_W+15:16];
        add_run = (mode == MODE_INTENSITY) ? PIXEL_WIDTH'(prod_reg)
                                           : PIXEL_WIDTH'(df_reg);
        sum_run = {1'b0, run_rd_reg} + {1'b0, add_run};
        sum_res = {1'b0, res_rd_reg} + {1'b0, PIXEL_WIDTH'(ext_reg)};
        sum_sw  = {1'b0, res_rd_reg} + {1'b0, run_rd_reg};
    end

    assign sts.action     = act_reg;
    assign sts.sweep_last = (sw_addr_reg == ADDR_W'(DEPTH - 1));
    assign res_value      = value_reg;
    assign res_sat        = sat_reg;

    // operands, control-side registers, memory reads and writes and the sweep
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            act_reg    <= in_action;
            x_reg      <= in_x;
            y_reg      <= in_y;
            br_reg     <= in_bright;
            df_reg     <= in_diff;
            row_in_reg <= in_row;
            col_in_reg <= in_col;
            ext_reg    <= in_ext;
            side_reg   <= side_eff;
            value_reg  <= '0;
            sat_reg    <= 1'b0;
        end
        if (cmd.op == OP_ADDR) begin
            prod_reg <= 40'(br_reg) * 40'(df_reg);
            if (act_reg == ACT_SAMPLE) begin
                addr_reg  <= {row_s, col_s};
                inreg_reg <= 1'b1;
            end else begin
                addr_reg  <= {row_in_reg[SIDE_W-1:0], col_in_reg[SIDE_W-1:0]};
                inreg_reg <= ((SIDE_W+1)'(row_in_reg) < side_reg)
                          && ((SIDE_W+1)'(col_in_reg) < side_reg);
            end
        end
        if (cmd.op == OP_RD) begin
            run_rd_reg <= run_mem[addr_reg];
            res_rd_reg <= res_mem[addr_reg];
        end
        if (cmd.op == OP_WR) begin
            if (act_reg == ACT_SAMPLE) begin
                if (mode == MODE_BW) begin
                    run_mem[addr_reg] <= ONE_Q16;
                end else if (mode == MODE_INTENSITY || mode == MODE_HIST) begin
                    run_mem[addr_reg] <= sum_run[PIXEL_WIDTH] ? PIX_MAX
                                       : sum_run[PIXEL_WIDTH-1:0];
                    sat_reg <= sum_run[PIXEL_WIDTH];
                end
            end else if (act_reg == ACT_READ) begin
                if (inreg_reg) value_reg <= OUT_W'(res_rd_reg);
            end else if (act_reg == ACT_COMBINE && inreg_reg) begin
                if (mode == MODE_BW) begin
                    if (PIXEL_WIDTH'(ext_reg) >= HALF_Q16) res_mem[addr_reg] <= ONE_Q16;
                end else if (mode == MODE_INTENSITY || mode == MODE_HIST) begin
                    res_mem[addr_reg] <= sum_res[PIXEL_WIDTH] ? PIX_MAX
                                       : sum_res[PIXEL_WIDTH-1:0];
                    sat_reg <= sum_res[PIXEL_WIDTH];
                end
            end
        end
        // sweep: read at sw_addr, write in the following cycle at sw_wa
        if (cmd.op == OP_SWEEP) begin
            run_rd_reg <= run_mem[sw_addr_reg];
            res_rd_reg <= res_mem[sw_addr_reg];
            sw_wa_reg  <= sw_addr_reg;
            sw_inreg_reg <= ((SIDE_W+1)'(sw_addr_reg[ADDR_W-1:SIDE_W]) < side_reg)
                         && ((SIDE_W+1)'(sw_addr_reg[SIDE_W-1:0]) < side_reg);
        end
        if (sw_vld_reg) begin
            if (cmd.clr_run || cmd.merge) run_mem[sw_wa_reg] <= '0;
            if (cmd.clr_res) begin
                res_mem[sw_wa_reg] <= '0;
            end else if (cmd.merge && sw_inreg_reg) begin
                if (mode == MODE_BW) begin
                    if (run_rd_reg > HALF_Q16) res_mem[sw_wa_reg] <= ONE_Q16;
                end else if (mode == MODE_INTENSITY || mode == MODE_HIST) begin
                    res_mem[sw_wa_reg] <= sum_sw[PIXEL_WIDTH] ? PIX_MAX
                                        : sum_sw[PIXEL_WIDTH-1:0];
                    if (sum_sw[PIXEL_WIDTH]) sat_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_addr_reg <= '0;
            sw_vld_reg  <= 1'b0;
        end else begin
            sw_vld_reg <= (cmd.op == OP_SWEEP);
            if (cmd.op == OP_SWEEP) sw_addr_reg <= sw_addr_reg + 1'b1;
        end
    end

endmodule

/* hw/rtl/iba_ctrl.sv */
// ----------------------------------------------------------------------------
// iba_ctrl
// sequencer: clear pass, per-item steps, merge sweep and result handshake
// ----------------------------------------------------------------------------
module iba_ctrl import iba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_fire,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output iba_cmd_t cmd,
    input  iba_sts_t sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       clr_reg, clr_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd.op      = OP_NONE;
        cmd.clr_run = clr_reg;
        cmd.clr_res = clr_reg;
        cmd.merge   = !clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                state_next = ST_SWEEP;
                clr_next   = 1'b1;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.op = OP_ADDR;
                clr_next = 1'b0;
                state_next = (sts.action == ACT_MERGE) ? ST_SWEEP : ST_RD;
            end
            ST_RD: begin
                cmd.op = OP_RD;
                state_next = ST_WR;
            end
            ST_WR: begin
                cmd.op = OP_WR;
                state_next = ST_OUT;
            end
            ST_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (sts.sweep_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = clr_reg ? ST_IDLE : ST_OUT;
                clr_next   = 1'b0;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> state_reg == ST_IDLE)
        else $error("accept outside idle");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready with pending result");

endmodule
